// ===== rtl/skhd_pkg.sv =====
`timescale 1ns / 1ps
package skhd_pkg;
	localparam logic [31:0] FNV_BASIS = 32'd2166136261;
	localparam logic [31:0] FNV_PRIME = 32'd16777619;

	localparam logic [1:0] CMD_LOOKUP = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_CLEAR  = 2'd2;
	localparam logic [1:0] CMD_DROP   = 2'd3;

	localparam logic [2:0] ST_FOUND    = 3'd0;
	localparam logic [2:0] ST_INSERTED = 3'd1;
	localparam logic [2:0] ST_REPLACED = 3'd2;
	localparam logic [2:0] ST_NOTFOUND = 3'd3;
	localparam logic [2:0] ST_BADLEN   = 3'd4;
	localparam logic [2:0] ST_FULL     = 3'd5;

	// controller to datapath
	typedef struct packed {
		logic take_byte;   // hash and buffer the accepted word
		logic start_op;    // latch key info, set probe start
		logic clr_init;    // start clear sweep
		logic clr_step;    // clear one slot
		logic rd_slot;     // issue entry/length read at probe index
		logic rd_word;     // issue key word read
		logic next_word;   // advance word counter
		logic next_slot;   // advance probe index
		logic wr_entry;    // write entry at probe index
		logic wr_key;      // write key word and length
		logic set_result;  // load output register
		logic [2:0] res_status;
	} skhd_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad_len;
		logic empty;       // probed entry empty
		logic len_eq;      // stored length matches
		logic word_eq;     // stored word matches
		logic word_last;   // word counter on final word
		logic probe_last;  // probed every active slot
		logic clr_last;    // clear sweep at final slot
		logic [1:0] op;
	} skhd_stat_t;
endpackage

// ===== rtl/skhd_datapath.sv =====
`timescale 1ns / 1ps
module skhd_datapath import skhd_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int MAX_KEY_BYTES = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [3:0]  cfg_log2,
	input  logic [1:0]  cmd,
	input  logic [7:0]  key_byte,
	input  logic [15:0] token_id,
	input  skhd_cmd_t   ctl,
	output skhd_stat_t  sts,
	output logic [2:0]  status,
	output logic [15:0] result_id
);
	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int KW = (MAX_KEY_BYTES + 7) / 8;
	localparam int WW = (KW > 1) ? $clog2(KW) : 1;
	localparam int LW = $clog2(MAX_KEY_BYTES + 1);
	localparam int SW = $clog2(TABLE_ENTRIES) + 1;
	localparam int FL = $clog2(TABLE_ENTRIES + 1) - 1;  // floor log2 of the depth
	localparam int KAW = (TABLE_ENTRIES * KW > 1) ? $clog2(TABLE_ENTRIES * KW) : 1;

	logic [15:0] entry_mem [TABLE_ENTRIES];
	logic [LW-1:0] len_mem [TABLE_ENTRIES];
	logic [63:0] key_mem [TABLE_ENTRIES*KW];
	logic [63:0] kbuf_q [KW];

	logic [31:0] hash_q;
	logic [LW-1:0] cnt_q, len_q;
	logic ovf_q;
	logic [1:0] op_q;
	logic [15:0] tid_q;
	logic [IW-1:0] idx_q, mask;
	logic [SW-1:0] probes_q, size;
	logic [WW-1:0] wcnt_q;
	logic [15:0] ent_rd_q;
	logic [LW-1:0] len_rd_q;
	logic [63:0] word_rd_q;
	logic [2:0] status_q;
	logic [15:0] rid_q;
	logic [31:0] hx;
	logic [31:0] hmul;
	logic [63:0] kword;
	logic [KAW-1:0] kaddr;
	logic [3:0] lg;

	// active slot count: log2 clamped to 1 and to the table depth
	always_comb begin
		lg = (cfg_log2 == 4'd0) ? 4'd1 : cfg_log2;
		if (32'(lg) > FL)
			lg = 4'(FL);
		size = SW'(1) << lg;
		mask = IW'(size - SW'(1));
	end

	// FNV-1a step, low 32 bits of the product only
	assign hx = hash_q ^ {24'd0, key_byte};
	assign hmul = hx * FNV_PRIME;

	// current key word, zero padded past the key length
	always_comb begin
		kword = kbuf_q[wcnt_q];
		for (int b = 0; b < 8; b++) begin
			if (32'(wcnt_q) * 8 + b >= 32'(len_q))
				kword[b*8 +: 8] = 8'd0;
		end
	end

	assign kaddr = KAW'(32'(idx_q) * KW + 32'(wcnt_q));

	// key gathering
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q <= FNV_BASIS;
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (ctl.take_byte) begin
			if (ctl.start_op) begin
				hash_q <= FNV_BASIS;
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				hash_q <= hmul;
				if (32'(cnt_q) < MAX_KEY_BYTES)
					cnt_q <= cnt_q + LW'(1);
				else
					ovf_q <= 1'b1;
			end
		end
	end

	// key bytes packed little-endian into words
	always_ff @(posedge clk) begin
		if (ctl.take_byte && 32'(cnt_q) < MAX_KEY_BYTES)
			kbuf_q[WW'(32'(cnt_q) / 8)][(32'(cnt_q) % 8) * 8 +: 8] <= key_byte;
	end

	// operation registers and probe walk
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= CMD_LOOKUP;
			len_q <= '0;
			tid_q <= '0;
			idx_q <= '0;
			probes_q <= '0;
			wcnt_q <= '0;
			status_q <= ST_NOTFOUND;
			rid_q <= '0;
		end else begin
			if (ctl.start_op) begin
				op_q <= cmd;
				tid_q <= (token_id == 16'hFFFF) ? 16'hFFFE : token_id;
				if (32'(cnt_q) < MAX_KEY_BYTES) begin
					len_q <= cnt_q + LW'(1);
				end else begin
					len_q <= cnt_q;
				end
				idx_q <= hmul[IW-1:0] & mask;
				probes_q <= '0;
				wcnt_q <= '0;
			end
			if (ctl.clr_init) begin
				idx_q <= '0;
			end else if (ctl.clr_step || ctl.next_slot) begin
				idx_q <= (idx_q + IW'(1)) & (ctl.clr_step ? IW'(TABLE_ENTRIES-1) : mask);
				probes_q <= probes_q + SW'(1);
				wcnt_q <= '0;
			end
			if (ctl.next_word)
				wcnt_q <= wcnt_q + WW'(1);
			if (ctl.set_result) begin
				status_q <= ctl.res_status;
				if (ctl.res_status == ST_FOUND)
					rid_q <= ent_rd_q - 16'd1;
				else if (ctl.res_status == ST_INSERTED || ctl.res_status == ST_REPLACED)
					rid_q <= tid_q;
				else
					rid_q <= '0;
			end
		end
	end

	// overflow flag travels with the op
	logic bad_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			bad_q <= 1'b0;
		else if (ctl.start_op)
			bad_q <= ovf_q || (32'(cnt_q) >= MAX_KEY_BYTES);
	end

	// slot memories
	always_ff @(posedge clk) begin
		if (ctl.clr_step)
			entry_mem[idx_q] <= '0;
		else if (ctl.wr_entry)
			entry_mem[idx_q] <= tid_q + 16'd1;
		if (ctl.rd_slot)
			ent_rd_q <= entry_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_key)
			len_mem[idx_q] <= len_q;
		if (ctl.rd_slot)
			len_rd_q <= len_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (ctl.wr_key)
			key_mem[kaddr] <= kword;
		if (ctl.rd_word)
			word_rd_q <= key_mem[kaddr];
	end

	always_comb begin
		sts.bad_len = bad_q;
		sts.empty = (ent_rd_q == 16'd0);
		sts.len_eq = (len_rd_q == len_q);
		sts.word_eq = (word_rd_q == kword);
		sts.word_last = (32'(wcnt_q) == KW - 1);
		sts.probe_last = (probes_q == size - SW'(1));
		sts.clr_last = (32'(idx_q) == TABLE_ENTRIES - 1);
		sts.op = op_q;
	end

	assign status = status_q;
	assign result_id = rid_q;
endmodule

// ===== rtl/skhd_ctrl.sv =====
`timescale 1ns / 1ps
module skhd_ctrl import skhd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       last,
	input  logic [1:0] cmd,
	output logic       in_ready,
	output logic       out_valid,
	input  logic       out_ready,
	input  skhd_stat_t sts,
	output skhd_cmd_t  ctl
);
	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_DISP  = 3'd1;
	localparam logic [2:0] S_RDS   = 3'd2;
	localparam logic [2:0] S_CHK   = 3'd3;
	localparam logic [2:0] S_CMP   = 3'd4;
	localparam logic [2:0] S_WRK   = 3'd5;
	localparam logic [2:0] S_CLR   = 3'd6;
	localparam logic [2:0] S_RDW   = 3'd7;

	logic [2:0] state_q, state_d;
	logic ov_q;
	logic acc;

	assign in_ready = (state_q == S_IDLE);
	assign acc = in_valid && in_ready;
	assign out_valid = ov_q;

	always_comb begin
		ctl = '0;
		ctl.res_status = ST_NOTFOUND;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					ctl.take_byte = 1'b1;
					if (last) begin
						ctl.start_op = 1'b1;
						if (cmd == CMD_CLEAR) begin
							ctl.clr_init = 1'b1;
							state_d = S_CLR;
						end else if (cmd inside {CMD_LOOKUP, CMD_INSERT}) begin
							state_d = S_DISP;
						end
					end
				end
			end
			S_DISP: begin
				// single result register: hold until the previous word leaves
				if (ov_q && !out_ready) begin
					state_d = S_DISP;
				end else if (sts.bad_len) begin
					ctl.set_result = 1'b1;
					ctl.res_status = ST_BADLEN;
					state_d = S_IDLE;
				end else begin
					ctl.rd_slot = 1'b1;
					state_d = S_RDS;
				end
			end
			S_RDS: begin
				ctl.rd_word = 1'b1;
				state_d = S_CHK;
			end
			S_CHK: begin
				if (sts.empty) begin
					if (sts.op == CMD_INSERT) begin
						ctl.wr_entry = 1'b1;
						ctl.wr_key = 1'b1;
						ctl.next_word = 1'b1;
						state_d = sts.word_last ? S_IDLE : S_WRK;
						ctl.set_result = sts.word_last;
						ctl.res_status = ST_INSERTED;
					end else begin
						ctl.set_result = 1'b1;
						ctl.res_status = ST_NOTFOUND;
						state_d = S_IDLE;
					end
				end else if (!sts.len_eq || !sts.word_eq) begin
					if (sts.probe_last) begin
						ctl.set_result = 1'b1;
						ctl.res_status = (sts.op == CMD_INSERT) ? ST_FULL : ST_NOTFOUND;
						state_d = S_IDLE;
					end else begin
						ctl.next_slot = 1'b1;
						state_d = S_DISP;
					end
				end else if (sts.word_last) begin
					ctl.set_result = 1'b1;
					if (sts.op == CMD_INSERT) begin
						ctl.wr_entry = 1'b1;
						ctl.res_status = ST_REPLACED;
					end else begin
						ctl.res_status = ST_FOUND;
					end
					state_d = S_IDLE;
				end else begin
					ctl.next_word = 1'b1;
					state_d = S_RDW;
				end
			end
			S_RDW: begin
				ctl.rd_word = 1'b1;
				state_d = S_CMP;
			end
			S_CMP: begin
				state_d = S_CHK;
			end
			S_WRK: begin
				ctl.wr_key = 1'b1;
				ctl.next_word = 1'b1;
				if (sts.word_last) begin
					ctl.set_result = 1'b1;
					ctl.res_status = ST_INSERTED;
					state_d = S_IDLE;
				end
			end
			S_CLR: begin
				ctl.clr_step = 1'b1;
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// reset starts a sweep that empties every slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.set_result)
				ov_q <= 1'b1;
			else if (out_ready)
				ov_q <= 1'b0;
		end
	end

`ifndef SYNTHESIS
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.take_byte |-> state_q == S_IDLE) else $error("byte taken while busy");
	a_res_once: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.set_result |-> !ov_q || out_ready) else $error("result overwritten");
	a_clr_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !ctl.set_result) else $error("clear gave result");
`endif
endmodule

// ===== rtl/string_key_hash_dictionary.sv =====
`timescale 1ns / 1ps
// String-keyed dictionary (FNV-1a hash, linear probing).
// Input channel in_valid/in_ready carries one key byte per word with cmd,
// last and token_id; only the last word's cmd and token_id count.
// Non-last words are taken one per cycle while idle. On the last word the
// block probes each slot visited with an entry/length read, a key word read
// and a compare, and each further key word with a read, a wait and a compare;
// an insert writes further key words one a cycle. A bad length answers unprobed.
// Clear sweeps every slot, one per cycle, and gives no result.
// Lookup and insert give one word on out_valid/out_ready. While it waits
// untaken, key words are still accepted, but the next lookup or insert
// holds before probing until the result register is free.
// After reset the block sweeps the slot memory empty with in_ready low,
// sets table_size_log2 to 12 and restarts the key hash.
// cfg_we writes table_size_log2 at once; write only while idle.
module string_key_hash_dictionary import skhd_pkg::*; #(
	parameter int TABLE_ENTRIES = 4096,
	parameter int MAX_KEY_BYTES = 63
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  key_byte,
	input  logic        last,
	input  logic [15:0] token_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [15:0] result_id
);
	logic [3:0] log2_q;
	skhd_cmd_t ctl;
	skhd_stat_t sts;

	// size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			log2_q <= 4'd12;
		else if (cfg_we)
			log2_q <= cfg_wdata;
	end

	skhd_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .last(last), .cmd(cmd),
		.in_ready(in_ready), .out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .ctl(ctl)
	);

	skhd_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_KEY_BYTES(MAX_KEY_BYTES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg_log2(log2_q), .cmd(cmd), .key_byte(key_byte),
		.token_id(token_id), .ctl(ctl), .sts(sts), .status(status), .result_id(result_id)
	);
endmodule
